// ===== design/cfa_pkg.sv =====
// shared codes for the complex fixed-point alu: operation codes, status codes
// and the pipeline control word; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cfa_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_GT    = 3'd4,
    OP_LT    = 3'd5,
    OP_INC   = 3'd6,
    OP_TRUNC = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic valid;
    op_t  op;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== design/cfa_div_step.sv =====
// one registered step of the restoring divider: brings in one numerator bit
// and produces one quotient bit; no package dependencies
`timescale 1ns / 1ps
`default_nettype none
module cfa_div_step #(
  parameter int MW = 64,
  parameter int QW = 33
) (
  input  logic          clk,
  input  logic [MW:0]   rem_in,
  input  logic [MW-1:0] den,
  input  logic          nbit,
  input  logic [QW-1:0] q_in,
  output logic [MW:0]   rem_out,
  output logic [QW-1:0] q_out
);

  logic [MW:0] trial;
  logic        ge;

  always_comb begin
    trial = {rem_in[MW-1:0], nbit};
    ge    = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    rem_out <= ge ? (trial - {1'b0, den}) : trial;
    q_out   <= {q_in[QW-2:0], ge};
  end

endmodule
`default_nettype wire

// ===== design/complex_fixed_point_alu_core.sv =====
// top level of the complex fixed-point alu: operand stages, multipliers,
// divider chain and result merge; uses cfa_pkg and cfa_div_step
//
// usage
//   a request is taken at a rising edge with start high and busy low; it
//   carries operation and the two complex operands a and b (fixed point,
//   FRAC_BITS fraction bits, low DATA_WIDTH bits used, capped at 32)
//   busy is low whenever rst is low: the pipeline takes a request every cycle
//   each request gives one result: done is high for one cycle with
//   result_real, result_imag, compare_true and status on the ports
//   latency: every operation goes through the same EW + 6 register stages,
//   EW being DATA_WIDTH capped at 32 (38 at the default width), so results
//   leave in request order
//   throughput: one request per cycle; the divider is a chain of one-bit
//   restoring steps, one register per quotient bit, which sets the depth
//   reset: clears the valid bits of every stage, done drops the cycle after
//   the receiver cannot stall: a result is on the ports for its one cycle
//   only, and nothing in the pipeline ever waits
//   status: 0 ok, 1 divide by zero (results zero), 2 a part saturated
`timescale 1ns / 1ps
`default_nettype none
module complex_fixed_point_alu_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation,
  input  logic signed [31:0] a_real,
  input  logic signed [31:0] a_imag,
  input  logic signed [31:0] b_real,
  input  logic signed [31:0] b_imag,
  output logic               done,
  output logic signed [31:0] result_real,
  output logic signed [31:0] result_imag,
  output logic               compare_true,
  output logic [1:0]         status
);
  import cfa_pkg::*;

  // effective width, product width, shifted numerator width
  localparam int EW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int MW = 2 * EW;
  localparam int NW = MW + FRAC_BITS;
  localparam int QW = EW + 1;

  localparam logic signed [65:0] SMAX = (66'sd1 <<< (EW - 1)) - 66'sd1;
  localparam logic signed [65:0] SMIN = -(66'sd1 <<< (EW - 1));

  // carried alongside the divider chain
  typedef struct packed {
    logic          is_div;
    logic          den_zero;
    logic          big_re;
    logic          big_im;
    logic          neg_re;
    logic          neg_im;
    logic [EW:0]   nlo_re;
    logic [EW:0]   nlo_im;
    logic [MW-1:0] den;
    logic [EW-1:0] fre;
    logic [EW-1:0] fim;
    logic          fcmp;
    logic [1:0]    fst;
  } carry_t;

  // sign/magnitude clamp, returns {sat, value}
  function automatic logic [EW:0] clamp_sm(input logic neg, input logic [MW:0] mag);
    logic [MW:0]   half;
    logic [MW:0]   negm;
    logic [EW:0]   res;
    half = (MW + 1)'(1) << (EW - 1);
    negm = -mag;
    if (neg) begin
      if (mag > half) res = {1'b1, 1'b1, {(EW - 1){1'b0}}};
      else            res = {1'b0, negm[EW-1:0]};
    end else begin
      if (mag > half - (MW + 1)'(1)) res = {1'b1, 1'b0, {(EW - 1){1'b1}}};
      else                           res = {1'b0, mag[EW-1:0]};
    end
    return res;
  endfunction

  // signed clamp on a wide value, returns {sat, value}
  function automatic logic [EW:0] clamp_s(input logic signed [65:0] v);
    logic [EW:0] res;
    if (v > SMAX)      res = {1'b1, 1'b0, {(EW - 1){1'b1}}};
    else if (v < SMIN) res = {1'b1, 1'b1, {(EW - 1){1'b0}}};
    else               res = {1'b0, v[EW-1:0]};
    return res;
  endfunction

  assign busy = rst;

  // stage 0: request registers
  ctrl_t                 ctrl0;
  logic signed [EW-1:0]  ar0, ai0, br0, bi0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl0.valid <= 1'b0;
    end else begin
      ctrl0.valid <= start;
    end
    ctrl0.op <= op_t'(operation);
    ar0      <= a_real[EW-1:0];
    ai0      <= a_imag[EW-1:0];
    br0      <= b_real[EW-1:0];
    bi0      <= b_imag[EW-1:0];
  end

  // stage 1: products and the simple operations
  ctrl_t                 ctrl1;
  logic signed [MW-1:0]  p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
  logic [EW-1:0]         sre1, sim1;
  logic                  scmp1, ssat1;
  logic [EW:0]           cl_a, cl_b;
  logic signed [65:0]    ar_w, ai_w, br_w, bi_w, tr_w;
  logic [EW-1:0]         sre_next, sim_next;
  logic                  scmp_next, ssat_next;

  always_comb begin
    ar_w      = 66'(ar0);
    ai_w      = 66'(ai0);
    br_w      = 66'(br0);
    bi_w      = 66'(bi0);
    tr_w      = (ar_w < 0) ? -((-ar_w) >> FRAC_BITS) : (ar_w >> FRAC_BITS);
    cl_a      = '0;
    cl_b      = '0;
    sre_next  = '0;
    sim_next  = '0;
    scmp_next = 1'b0;
    ssat_next = 1'b0;
    case (ctrl0.op)
      OP_ADD: begin
        cl_a      = clamp_s(ar_w + br_w);
        cl_b      = clamp_s(ai_w + bi_w);
        sre_next  = cl_a[EW-1:0];
        sim_next  = cl_b[EW-1:0];
        ssat_next = cl_a[EW] | cl_b[EW];
      end
      OP_SUB: begin
        cl_a      = clamp_s(ar_w - br_w);
        cl_b      = clamp_s(ai_w - bi_w);
        sre_next  = cl_a[EW-1:0];
        sim_next  = cl_b[EW-1:0];
        ssat_next = cl_a[EW] | cl_b[EW];
      end
      OP_GT:    scmp_next = (ar0 > br0) && (ai0 > bi0);
      OP_LT:    scmp_next = (ar0 < br0) && (ai0 < bi0);
      OP_INC: begin
        cl_a      = clamp_s(ar_w + (66'sd1 <<< FRAC_BITS));
        sre_next  = cl_a[EW-1:0];
        sim_next  = ai0;
        ssat_next = cl_a[EW];
      end
      OP_TRUNC: sre_next = tr_w[EW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1.valid <= 1'b0;
    end else begin
      ctrl1.valid <= ctrl0.valid;
    end
    ctrl1.op <= ctrl0.op;
    p_rr     <= ar0 * br0;
    p_ii     <= ai0 * bi0;
    p_ri     <= ar0 * bi0;
    p_ir     <= ai0 * br0;
    sq_r     <= br0 * br0;
    sq_i     <= bi0 * bi0;
    sre1     <= sre_next;
    sim1     <= sim_next;
    scmp1    <= scmp_next;
    ssat1    <= ssat_next;
  end

  // stage 2: product sums as sign and magnitude, divisor
  ctrl_t                 ctrl2;
  logic                  neg2_re, neg2_im;
  logic [MW-1:0]         mag2_re, mag2_im, den2;
  logic [EW-1:0]         sre2, sim2;
  logic                  scmp2, ssat2;
  logic signed [MW:0]    sum_re, sum_im, abs_re, abs_im;

  always_comb begin
    if (ctrl1.op == OP_DIV) begin
      sum_re = (MW + 1)'(p_rr) + (MW + 1)'(p_ii);
      sum_im = (MW + 1)'(p_ir) - (MW + 1)'(p_ri);
    end else begin
      sum_re = (MW + 1)'(p_rr) - (MW + 1)'(p_ii);
      sum_im = (MW + 1)'(p_ri) + (MW + 1)'(p_ir);
    end
    abs_re = sum_re[MW] ? -sum_re : sum_re;
    abs_im = sum_im[MW] ? -sum_im : sum_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl2.valid <= 1'b0;
    end else begin
      ctrl2.valid <= ctrl1.valid;
    end
    ctrl2.op <= ctrl1.op;
    neg2_re  <= sum_re[MW];
    neg2_im  <= sum_im[MW];
    mag2_re  <= abs_re[MW-1:0];
    mag2_im  <= abs_im[MW-1:0];
    den2     <= sq_r[MW-1:0] + sq_i[MW-1:0];
    sre2     <= sre1;
    sim2     <= sim1;
    scmp2    <= scmp1;
    ssat2    <= ssat1;
  end

  // stage 3: multiply result, divider set-up and overflow pre-check
  logic          vld  [0:QW];
  carry_t        cry  [0:QW];
  logic [MW:0]   rem_re [0:QW];
  logic [MW:0]   rem_im [0:QW];
  logic [QW-1:0] q_re [0:QW];
  logic [QW-1:0] q_im [0:QW];
  logic [MW:0]   rem0_re, rem0_im;

  logic [NW-1:0] num_re, num_im, sh_re, sh_im;
  logic [EW:0]   mul_re, mul_im;
  carry_t        cry_next;

  always_comb begin
    num_re   = {mag2_re, {FRAC_BITS{1'b0}}};
    num_im   = {mag2_im, {FRAC_BITS{1'b0}}};
    sh_re    = num_re >> QW;
    sh_im    = num_im >> QW;
    mul_re   = clamp_sm(neg2_re, {1'b0, mag2_re >> FRAC_BITS});
    mul_im   = clamp_sm(neg2_im, {1'b0, mag2_im >> FRAC_BITS});
    cry_next = '0;
    cry_next.is_div   = (ctrl2.op == OP_DIV);
    cry_next.den_zero = (den2 == '0);
    cry_next.big_re   = sh_re >= NW'(den2);
    cry_next.big_im   = sh_im >= NW'(den2);
    cry_next.neg_re   = neg2_re;
    cry_next.neg_im   = neg2_im;
    cry_next.nlo_re   = num_re[EW:0];
    cry_next.nlo_im   = num_im[EW:0];
    cry_next.den      = den2;
    if (ctrl2.op == OP_MUL) begin
      cry_next.fre = mul_re[EW-1:0];
      cry_next.fim = mul_im[EW-1:0];
      cry_next.fst = (mul_re[EW] | mul_im[EW]) ? ST_SAT : ST_OK;
    end else begin
      cry_next.fre  = sre2;
      cry_next.fim  = sim2;
      cry_next.fcmp = scmp2;
      cry_next.fst  = ssat2 ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= ctrl2.valid;
    end
    cry[0]  <= cry_next;
    rem0_re <= sh_re[MW:0];
    rem0_im <= sh_im[MW:0];
  end

  // the chain head; every quotient bit is shifted in by the steps
  assign rem_re[0] = rem0_re;
  assign rem_im[0] = rem0_im;
  assign q_re[0]   = '0;
  assign q_im[0]   = '0;

  // divider chain, one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_div
    cfa_div_step #(.MW(MW), .QW(QW)) u_step_re (
      .clk     (clk),
      .rem_in  (rem_re[k]),
      .den     (cry[k].den),
      .nbit    (cry[k].nlo_re[EW-k]),
      .q_in    (q_re[k]),
      .rem_out (rem_re[k+1]),
      .q_out   (q_re[k+1])
    );
    cfa_div_step #(.MW(MW), .QW(QW)) u_step_im (
      .clk     (clk),
      .rem_in  (rem_im[k]),
      .den     (cry[k].den),
      .nbit    (cry[k].nlo_im[EW-k]),
      .q_in    (q_im[k]),
      .rem_out (rem_im[k+1]),
      .q_out   (q_im[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      cry[k+1] <= cry[k];
    end
  end

  // final stage: quotient clamp and merge
  carry_t        cf;
  logic [EW:0]   dq_re, dq_im;
  logic [EW-1:0] out_re_next, out_im_next;
  logic          out_cmp_next;
  logic [1:0]    out_st_next;
  logic signed [EW-1:0] out_re, out_im;

  always_comb begin
    cf    = cry[QW];
    dq_re = clamp_sm(cf.neg_re, cf.big_re ? {(MW + 1){1'b1}} : (MW + 1)'(q_re[QW]));
    dq_im = clamp_sm(cf.neg_im, cf.big_im ? {(MW + 1){1'b1}} : (MW + 1)'(q_im[QW]));
    out_re_next  = cf.fre;
    out_im_next  = cf.fim;
    out_cmp_next = cf.fcmp;
    out_st_next  = cf.fst;
    if (cf.is_div) begin
      out_cmp_next = 1'b0;
      if (cf.den_zero) begin
        out_re_next = '0;
        out_im_next = '0;
        out_st_next = ST_DIV0;
      end else begin
        out_re_next = dq_re[EW-1:0];
        out_im_next = dq_im[EW-1:0];
        out_st_next = (dq_re[EW] | dq_im[EW]) ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[QW];
    end
    out_re       <= out_re_next;
    out_im       <= out_im_next;
    compare_true <= out_cmp_next;
    status       <= out_st_next;
  end

  assign result_real = 32'(out_re);
  assign result_imag = 32'(out_im);

endmodule
`default_nettype wire

// ===== design/cfa_checker.sv =====
// port-level checks for the complex fixed-point alu and their bind to the
// top level; uses cfa_pkg status codes
`timescale 1ns / 1ps
`default_nettype none
module cfa_checker #(
  parameter int DATA_WIDTH = 32
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [31:0] result_real,
  input wire logic [31:0] result_imag,
  input wire logic        done,
  input wire logic        compare_true,
  input wire logic [1:0]  status
);
  import cfa_pkg::*;

  localparam int EW  = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int LAT = EW + 6;

  // every result traces back to a request a fixed number of cycles earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching request");

  a_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  a_div0: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_DIV0 |-> result_real == '0 && result_imag == '0 && !compare_true)
    else $error("divide by zero with non-zero result");

  a_cmp: assert property (@(posedge clk) disable iff (rst)
    done && compare_true |-> status == ST_OK && result_real == '0 && result_imag == '0)
    else $error("compare result with data or status");

  a_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status != 2'd3)
    else $error("undefined status code");

endmodule

bind complex_fixed_point_alu_core cfa_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cfa_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_real  (result_real),
  .result_imag  (result_imag),
  .done         (done),
  .compare_true (compare_true),
  .status       (status)
);
`default_nettype wire

// ===== dv/tb.sv =====
// testbench for complex_fixed_point_alu_core: directed table then random requests,
// each result checked against a hand-written row expectation or an in-bench q16.16 complex
// arithmetic predictor; depends on cfa_pkg and the design files
`timescale 1ns / 1ps
module tb;
  import cfa_pkg::*;

  // expected outcome of one request
  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               cmp;
    logic [1:0]         st;
  } alu_res_t;

  // one row of the directed table; has_typed marks a hand-written expectation
  typedef struct {
    op_t                op;
    logic signed [31:0] ar, ai, br, bi;
    bit                 has_typed;
    alu_res_t           typed;
  } stim_row_t;

  localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         operation = '0;
  logic signed [31:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
  logic               done;
  logic signed [31:0] result_real, result_imag;
  logic               compare_true;
  logic [1:0]         status;

  alu_res_t pending_results[$];
  int       mismatches = 0;

  always #5 clk = ~clk;

  complex_fixed_point_alu_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
    .done(done), .result_real(result_real), .result_imag(result_imag),
    .compare_true(compare_true), .status(status)
  );

  // clamp a sign/magnitude value into the 32-bit signed range
  function automatic logic signed [31:0] clamp_sm(input bit neg, input logic [127:0] mag,
                                                  inout bit sat);
    if (neg) begin
      if (mag > 128'h8000_0000) begin
        sat = 1'b1;
        return MINV;
      end
      return -mag[31:0];
    end
    if (mag > 128'h7fff_ffff) begin
      sat = 1'b1;
      return MAXV;
    end
    return mag[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_wide(input logic signed [127:0] v, inout bit sat);
    logic [127:0] m;
    m = (v < 0) ? -v : v;
    return clamp_sm(v < 0, m, sat);
  endfunction

  // exact complex arithmetic in 128 bits, rounding toward zero, then saturation
  function automatic alu_res_t complex_alu_result(input op_t op,
      input logic signed [31:0] a_r, a_i, b_r, b_i);
    alu_res_t r;
    bit sat;
    logic signed [127:0] xr, xi, yr, yi, s;
    logic [127:0] mag, den;
    sat = 1'b0;
    r = '{re: '0, im: '0, cmp: 1'b0, st: ST_OK};
    xr = a_r; xi = a_i; yr = b_r; yi = b_i;
    case (op)
      OP_ADD: begin
        r.re = clamp_wide(xr + yr, sat);
        r.im = clamp_wide(xi + yi, sat);
      end
      OP_SUB: begin
        r.re = clamp_wide(xr - yr, sat);
        r.im = clamp_wide(xi - yi, sat);
      end
      OP_MUL: begin
        s = xr * yr - xi * yi;
        mag = (s < 0) ? -s : s;
        r.re = clamp_sm(s < 0, mag >> 16, sat);
        s = xr * yi + xi * yr;
        mag = (s < 0) ? -s : s;
        r.im = clamp_sm(s < 0, mag >> 16, sat);
      end
      OP_DIV: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.st = ST_DIV0;
        end else begin
          s = xr * yr + xi * yi;
          mag = (s < 0) ? -s : s;
          r.re = clamp_sm(s < 0, (mag << 16) / den, sat);
          s = xi * yr - xr * yi;
          mag = (s < 0) ? -s : s;
          r.im = clamp_sm(s < 0, (mag << 16) / den, sat);
        end
      end
      OP_GT: r.cmp = (xr > yr) && (xi > yi);
      OP_LT: r.cmp = (xr < yr) && (xi < yi);
      OP_INC: begin
        r.re = clamp_wide(xr + 128'sh1_0000, sat);
        r.im = a_i;
      end
      default: begin
        s = (xr < 0) ? -((-xr) >> 16) : (xr >> 16);
        r.re = s[31:0];
      end
    endcase
    if (sat && r.st == ST_OK) r.st = ST_SAT;
    return r;
  endfunction

  // present one request from the falling edge until it is taken
  task automatic issue_request(input op_t op, input logic signed [31:0] a_r, a_i, b_r, b_i,
                               input alu_res_t exp_res);
    @(negedge clk);
    start = 1'b1;
    operation = op;
    a_real = a_r; a_imag = a_i; b_real = b_r; b_imag = b_i;
    do @(posedge clk); while (busy);
    pending_results.push_back(exp_res);
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // operand mix: full random, small values near zero, or an extreme
  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return MAXV;
      1:       return MINV;
      2:       return '0;
      3, 4:    return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      5:       return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default: return $urandom();
    endcase
  endfunction

  // result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin
    alu_res_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: re %h im %h",
                                       result_real, result_imag);
      end else begin
        e = pending_results.pop_front();
        if (result_real !== e.re || result_imag !== e.im || compare_true !== e.cmp ||
            status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected re %h im %h cmp %b st %0d, got re %h im %h cmp %b st %0d",
                     e.re, e.im, e.cmp, e.st, result_real, result_imag, compare_true, status);
        end
      end
    end
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb failed");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    alu_res_t  exp_res;
    op_t       op;
    int        burst;

    // extremes, every operation, divide by zero, saturation and truncation sign
    rows = '{
      '{OP_ADD,   MAXV, MINV, ONE, -ONE, 1'b1, '{MAXV, MINV, 1'b0, ST_SAT}},
      '{OP_ADD,   ONE, ONE, ONE, ONE, 1'b1, '{32'sh2_0000, 32'sh2_0000, 1'b0, ST_OK}},
      '{OP_SUB,   MINV, MAXV, ONE, -ONE, 1'b1, '{MINV, MAXV, 1'b0, ST_SAT}},
      '{OP_SUB,   '0, '0, MINV, '0, 1'b1, '{MAXV, '0, 1'b0, ST_SAT}},
      '{OP_MUL,   ONE, '0, ONE, '0, 1'b1, '{ONE, '0, 1'b0, ST_OK}},
      '{OP_MUL,   MAXV, MAXV, MAXV, MAXV, 1'b0, '{'0, '0, 1'b0, ST_OK}},
      '{OP_MUL,   MINV, MINV, MINV, MINV, 1'b0, '{'0, '0, 1'b0, ST_OK}},
      '{OP_MUL,   -32'sd3, 32'sd5, 32'sd7, -32'sd1, 1'b0, '{'0, '0, 1'b0, ST_OK}},
      '{OP_DIV,   ONE, ONE, '0, '0, 1'b1, '{'0, '0, 1'b0, ST_DIV0}},
      '{OP_DIV,   MINV, MAXV, '0, '0, 1'b1, '{'0, '0, 1'b0, ST_DIV0}},
      '{OP_DIV,   ONE, '0, ONE, '0, 1'b1, '{ONE, '0, 1'b0, ST_OK}},
      '{OP_DIV,   MAXV, MINV, 32'sd1, '0, 1'b0, '{'0, '0, 1'b0, ST_OK}},
      '{OP_DIV,   MINV, MINV, MINV, MINV, 1'b0, '{'0, '0, 1'b0, ST_OK}},
      '{OP_DIV,   -32'sd7, 32'sd3, MAXV, -32'sd1, 1'b0, '{'0, '0, 1'b0, ST_OK}},
      '{OP_GT,    32'sd2, 32'sd2, 32'sd1, 32'sd1, 1'b1, '{'0, '0, 1'b1, ST_OK}},
      '{OP_GT,    32'sd2, 32'sd1, 32'sd1, 32'sd1, 1'b1, '{'0, '0, 1'b0, ST_OK}},
      '{OP_LT,    MINV, MINV, MAXV, MAXV, 1'b1, '{'0, '0, 1'b1, ST_OK}},
      '{OP_LT,    '0, MINV, '0, MAXV, 1'b1, '{'0, '0, 1'b0, ST_OK}},
      '{OP_INC,   MAXV, MINV, MAXV, MAXV, 1'b1, '{MAXV, MINV, 1'b0, ST_SAT}},
      '{OP_INC,   -ONE, 32'sd5, '0, '0, 1'b1, '{'0, 32'sd5, 1'b0, ST_OK}},
      '{OP_TRUNC, 32'sh0002_8000, ONE, ONE, ONE, 1'b1, '{32'sd2, '0, 1'b0, ST_OK}},
      '{OP_TRUNC, -32'sh0002_8000, '0, '0, '0, 1'b1, '{-32'sd2, '0, 1'b0, ST_OK}},
      '{OP_TRUNC, MINV, MAXV, MINV, MAXV, 1'b1, '{-32'sd32768, '0, 1'b0, ST_OK}},
      '{OP_TRUNC, MAXV, '0, '0, '0, 1'b1, '{32'sd32767, '0, 1'b0, ST_OK}}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      exp_res = rows[i].has_typed ? rows[i].typed
              : complex_alu_result(rows[i].op, rows[i].ar, rows[i].ai, rows[i].br, rows[i].bi);
      issue_request(rows[i].op, rows[i].ar, rows[i].ai, rows[i].br, rows[i].bi, exp_res);
    end

    // drain the pipeline once before the random part
    hold_off(1);
    wait (pending_results.size() == 0);

    for (int n = 0; n < 2000; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < 2000; k++, n++) begin
        logic signed [31:0] a_r, a_i, b_r, b_i;
        op = op_t'($urandom_range(0, 7));
        a_r = rand_operand(); a_i = rand_operand();
        b_r = rand_operand(); b_i = rand_operand();
        // force the odd zero divisor
        if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
          b_r = '0;
          b_i = '0;
        end
        issue_request(op, a_r, a_i, b_r, b_i, complex_alu_result(op, a_r, a_i, b_r, b_i));
      end
      // gaps of random length, often none, so idle cycles land on every stage
      if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 45));
    end
    hold_off(1);

    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/cfa_pkg.sv
design/cfa_div_step.sv
design/complex_fixed_point_alu_core.sv
design/cfa_checker.sv
dv/tb.sv
